/* rtl/top_k_per_group_selector_macros.svh */
// Assertion macros for the top-k per group selector.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TOP_K_PER_GROUP_SELECTOR_MACROS_SVH
`define TOP_K_PER_GROUP_SELECTOR_MACROS_SVH

// Check sampled on the rising clock edge, switched off while reset is asserted.
`define TKPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check sampled on every rising clock edge, reset included.
`define TKPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tkps_pkg.sv */
// Shared types and constants for the top-k per group selector.
// Used by tkps_cell and top_k_per_group_selector; no dependencies.
`default_nettype none

package tkps_pkg;

	localparam int unsigned TKPS_TOP_K = 3;
	localparam int unsigned HOUR_W     = 5;
	localparam int unsigned ID_W       = 16;
	localparam int unsigned COUNT_W    = 16;

	localparam logic [HOUR_W-1:0] CUTOFF_RESET = 5'd13;

	// One ranked entry: valid flag, source id and count.
	typedef struct packed {
		logic               v;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] cnt;
	} tkps_entry_t;

	// Link between neighbouring cells of the ranking row.
	typedef struct packed {
		logic        take;
		tkps_entry_t e;
	} tkps_link_t;

	// Commands broadcast from the control to every cell.
	typedef struct packed {
		logic               ins;
		logic               clr;
		logic               load;
		logic               pop;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] cnt;
	} tkps_ctrl_t;

endpackage

`default_nettype wire

/* rtl/tkps_cell.sv */
// One cell of the ranking row: a working slot and a report slot.
// Depends on tkps_pkg.
`default_nettype none

module tkps_cell
	import tkps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tkps_ctrl_t  ctrl,
	input  tkps_link_t  link_in,
	output tkps_link_t  link_out,
	input  tkps_entry_t rep_in,
	output tkps_entry_t rep_out
);

	logic               work_v_q;
	logic [ID_W-1:0]    work_id_q;
	logic [COUNT_W-1:0] work_cnt_q;
	logic               rep_v_q;
	logic [ID_W-1:0]    rep_id_q;
	logic [COUNT_W-1:0] rep_cnt_q;
	logic               eff_v;
	logic               take;

	// A cleared row looks empty to the record inserted in the same cycle.
	assign eff_v = work_v_q & ~ctrl.clr;
	assign take  = ctrl.ins & (~eff_v | (work_cnt_q <= ctrl.cnt));

	assign link_out.take  = take;
	assign link_out.e.v   = eff_v;
	assign link_out.e.id  = work_id_q;
	assign link_out.e.cnt = work_cnt_q;

	assign rep_out.v   = rep_v_q;
	assign rep_out.id  = rep_id_q;
	assign rep_out.cnt = rep_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			rep_v_q  <= 1'b0;
		end else begin
			if (link_in.take) begin
				work_v_q <= link_in.e.v;
			end else if (take) begin
				work_v_q <= 1'b1;
			end else begin
				work_v_q <= eff_v;
			end
			if (ctrl.load) begin
				rep_v_q <= work_v_q;
			end else if (ctrl.pop) begin
				rep_v_q <= rep_in.v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.take) begin
			work_id_q  <= link_in.e.id;
			work_cnt_q <= link_in.e.cnt;
		end else if (take) begin
			work_id_q  <= ctrl.id;
			work_cnt_q <= ctrl.cnt;
		end
		if (ctrl.load) begin
			rep_id_q  <= work_id_q;
			rep_cnt_q <= work_cnt_q;
		end else if (ctrl.pop) begin
			rep_id_q  <= rep_in.id;
			rep_cnt_q <= rep_in.cnt;
		end
	end

endmodule

`default_nettype wire

/* rtl/top_k_per_group_selector.sv */
// Top level of the top-k per group selector: control, cutoff register and cell row.
// Depends on tkps_pkg, tkps_cell and top_k_per_group_selector_macros.svh.
// The block takes one item per clock cycle. Each item is ranked into a row of
// TOP_K cells in the cycle it is accepted, largest count first, a later item
// winning ties. When an item opens a new hour, the whole row is copied into the
// report slots of the same cells in that cycle and then shifts out one entry per
// cycle while out_stall is low, largest first, with last set on the final one.
// Items keep flowing during the report; only an item that would open yet another
// hour is stalled, until the final entry of the pending report leaves, which may
// happen in the same cycle. An item whose hour is at or above the cutoff register
// halts the block: the open group is dropped, and all later items are accepted
// and ignored until reset. A report already under way still drains.
`default_nettype none

module top_k_per_group_selector
	import tkps_pkg::*;
#(
	parameter int unsigned TOP_K = TKPS_TOP_K
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [HOUR_W-1:0]  cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [HOUR_W-1:0]  hour,
	input  logic [ID_W-1:0]    source_id,
	input  logic [COUNT_W-1:0] vehicle_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [HOUR_W-1:0]  group_hour,
	output logic [ID_W-1:0]    ranked_id,
	output logic [COUNT_W-1:0] ranked_count,
	output logic               last
);

`include "top_k_per_group_selector_macros.svh"

	logic [HOUR_W-1:0] cutoff_q;
	logic [HOUR_W-1:0] open_hour_q;
	logic [HOUR_W-1:0] group_hour_q;
	logic              group_open_q;
	logic              halted_q;

	logic        is_halt;
	logic        is_change;
	logic        busy;
	logic        acc;
	logic        act;
	tkps_ctrl_t  ctrl;

	// Working links run left to right, report links right to left.
	tkps_link_t  wl [0:TOP_K];
	tkps_entry_t rl [0:TOP_K];

	assign is_halt   = hour >= cutoff_q;
	assign is_change = group_open_q && (hour != open_hour_q);
	// The report slots count as free in the cycle in which their final entry leaves.
	assign busy      = rl[0].v && !(ctrl.pop && !rl[1].v);

	// Only a record that closes a group has to wait for the report slots.
	assign in_stall = !halted_q && !is_halt && is_change && busy;
	assign acc      = in_valid && !in_stall;
	assign act      = acc && !halted_q;

	assign ctrl.ins  = act && !is_halt;
	assign ctrl.clr  = act && (is_halt || is_change);
	assign ctrl.load = act && !is_halt && is_change;
	assign ctrl.pop  = out_valid && !out_stall;
	assign ctrl.id   = source_id;
	assign ctrl.cnt  = vehicle_count;

	assign wl[0]     = '0;
	assign rl[TOP_K] = '0;

	for (genvar g = 0; g < TOP_K; g++) begin : g_cell
		tkps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.link_in (wl[g]),
			.link_out(wl[g+1]),
			.rep_in  (rl[g+1]),
			.rep_out (rl[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q     <= CUTOFF_RESET;
			open_hour_q  <= '0;
			group_open_q <= 1'b0;
			halted_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cutoff_q <= cfg_wr_data;
			end
			if (act) begin
				if (is_halt) begin
					halted_q     <= 1'b1;
					group_open_q <= 1'b0;
				end else begin
					open_hour_q  <= hour;
					group_open_q <= 1'b1;
				end
			end
		end
	end

	// The hour of the group in the report slots is captured with the row.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			group_hour_q <= open_hour_q;
		end
	end

	assign out_valid    = rl[0].v;
	assign group_hour   = group_hour_q;
	assign ranked_id    = rl[0].id;
	assign ranked_count = rl[0].cnt;
	assign last         = !rl[1].v;

	// The report row is only ever loaded when it is empty.
	`TKPS_ASSERT(a_load_when_empty, ctrl.load |-> !busy, "report row loaded while busy")
	// Halting is permanent until reset.
	`TKPS_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halted state was left")
	// A halted block keeps no working entries.
	`TKPS_ASSERT(a_halt_empty, halted_q |-> !wl[1].e.v, "working row not empty after halt")
	// Reported entries leave in descending order of count.
	`TKPS_ASSERT(a_report_sorted, (rl[0].v && rl[1].v) |-> (rl[0].cnt >= rl[1].cnt),
		"report row out of order")

endmodule

`default_nettype wire
